@@ src/tecf_pkg.sv @@
`default_nettype none
package tecf_pkg;

    localparam int LEVEL_BITS = 24;
    localparam int RGB_W      = 24;
    localparam int IN_W       = 24;

    // Residual channels stay below four times full scale, their sums below 2^(RES_W+2).
    localparam int RES_W  = LEVEL_BITS + 2;
    localparam int SUM_W  = RES_W + 2;
    localparam int NUM_W  = RES_W + 8;
    localparam int HI_W   = NUM_W - LEVEL_BITS;
    localparam int PROD_W = LEVEL_BITS + 8;

    localparam int BPS      = 4;
    localparam int DIV_ST   = (LEVEL_BITS + BPS - 1) / BPS;
    localparam int N_ST     = DIV_ST + 6;
    localparam int N_PHASE  = 9;
    localparam int N_GREEDY = 3;

    localparam logic [LEVEL_BITS-1:0] MAXV = '1;

    // Exact floor(x / 255) for any 32-bit x.
    localparam int          MAGIC_W      = 32;
    localparam logic [31:0] DIV255_MAGIC = 32'h80808081;
    localparam int          DIV255_SHIFT = 39;

    localparam logic [1:0] REG_COLOR_A = 2'd0;
    localparam logic [1:0] REG_COLOR_B = 2'd1;
    localparam logic [1:0] REG_COLOR_C = 2'd2;

    localparam logic [1:0] PH_DONOR [N_PHASE] =
        '{2'd0, 2'd1, 2'd2, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2};
    localparam logic [1:0] PH_RECV [N_PHASE] =
        '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2, 2'd0, 2'd0, 2'd1};

    typedef logic [RGB_W-1:0]      rgb_t;
    typedef logic [LEVEL_BITS-1:0] lvl_t;
    typedef logic [RES_W-1:0]      res_t;

    typedef struct packed {
        res_t [2:0] res;
        lvl_t [2:0] drv;
    } tecf_item_t;

    typedef struct packed {
        logic       is_xfer;
        logic [1:0] d_idx;
        logic [1:0] r_idx;
        rgb_t       fit_rgb;
        rgb_t       add_rgb;
        rgb_t       sub_rgb;
    } tecf_ctl_t;

    // Channel 0 is red in the top byte, channel 2 blue in the bottom byte.
    function automatic logic [7:0] rgb_byte(input rgb_t rgb, input logic [1:0] ch);
        logic [7:0] b;
        unique case (ch)
            2'd0:    b = rgb[23:16];
            2'd1:    b = rgb[15:8];
            2'd2:    b = rgb[7:0];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    function automatic rgb_t rgb_diff(input rgb_t recv, input rgb_t donor);
        rgb_t       d;
        logic [7:0] rv;
        logic [7:0] dv;
        d = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            rv = rgb_byte(recv, 2'(ch));
            dv = rgb_byte(donor, 2'(ch));
            d[16 - 8 * ch +: 8] = (rv > dv) ? 8'(rv - dv) : 8'd0;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

@@ src/tecf_phase.sv @@
`default_nettype none
module tecf_phase (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire tecf_pkg::tecf_ctl_t     ctl,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire tecf_pkg::tecf_item_t    in_item,
    output logic                         out_valid,
    input  wire                          out_ready,
    output tecf_pkg::tecf_item_t         out_item
);
    import tecf_pkg::*;

    localparam int ST_MIN   = DIV_ST + 1;
    localparam int ST_MUL1  = DIV_ST + 2;
    localparam int ST_MUL2  = DIV_ST + 3;
    localparam int ST_TRIAL = DIV_ST + 4;
    localparam int ST_UPD   = DIV_ST + 5;

    typedef struct packed {
        tecf_item_t                item;
        lvl_t                      cap;
        logic [2:0]                sat;
        logic [2:0][7:0]           rem;
        lvl_t [2:0]                quo;
        lvl_t                      f;
        logic [5:0][PROD_W-1:0]    prod;
        lvl_t [5:0]                part;
        res_t [2:0]                trial;
        logic [SUM_W-1:0]          sum_old;
    } rec_t;

    rec_t            rec_reg  [N_ST];
    rec_t            rec_next [N_ST];
    logic [N_ST-1:0] vld_reg;
    logic [N_ST-1:0] en;

    // Prepare: scaled numerator, saturation test and the transfer cap.
    always_comb
    begin
        rec_t             r;
        logic [NUM_W-1:0] num;
        logic [HI_W-1:0]  hi;
        logic [7:0]       v;
        lvl_t             dd;
        lvl_t             head;
        r = '0;
        r.item = in_item;
        for (int ch = 0; ch < 3; ch++)
        begin
            v   = rgb_byte(ctl.fit_rgb, 2'(ch));
            num = {in_item.res[ch], 8'd0} - NUM_W'(in_item.res[ch]);
            hi  = num[NUM_W-1:LEVEL_BITS];
            r.sat[ch] = (v == 8'd0) || (hi >= HI_W'(v));
            r.rem[ch] = hi[7:0];
            r.quo[ch] = num[LEVEL_BITS-1:0];
        end
        dd   = in_item.drv[ctl.d_idx];
        head = MAXV - in_item.drv[ctl.r_idx];
        if (ctl.is_xfer)
        begin
            r.cap = (dd < head) ? dd : head;
        end
        else
        begin
            r.cap = MAXV;
        end
        rec_next[0] = r;
    end

    // Restoring division, BPS quotient bits per stage; quo shifts numerator bits out
    // at the top and quotient bits in at the bottom.
    for (genvar s = 0; s < DIV_ST; s++)
    begin : g_div
        always_comb
        begin
            rec_t       r;
            logic [8:0] r9;
            logic [7:0] v;
            r = rec_reg[s];
            for (int ch = 0; ch < 3; ch++)
            begin
                v = rgb_byte(ctl.fit_rgb, 2'(ch));
                for (int b = 0; b < BPS; b++)
                begin
                    if (s * BPS + b < LEVEL_BITS)
                    begin
                        r9 = {r.rem[ch], r.quo[ch][LEVEL_BITS-1]};
                        r.quo[ch] = {r.quo[ch][LEVEL_BITS-2:0], 1'b0};
                        if (r9 >= {1'b0, v})
                        begin
                            r.rem[ch]    = 8'(r9 - {1'b0, v});
                            r.quo[ch][0] = 1'b1;
                        end
                        else
                        begin
                            r.rem[ch] = r9[7:0];
                        end
                    end
                end
            end
            rec_next[s + 1] = r;
        end
    end

    always_comb
    begin
        rec_t r;
        lvl_t q;
        r = rec_reg[ST_MIN - 1];
        r.f = r.cap;
        for (int ch = 0; ch < 3; ch++)
        begin
            q = r.sat[ch] ? MAXV : r.quo[ch];
            if (q < r.f)
            begin
                r.f = q;
            end
        end
        rec_next[ST_MIN] = r;
    end

    always_comb
    begin
        rec_t r;
        r = rec_reg[ST_MUL1 - 1];
        for (int ch = 0; ch < 3; ch++)
        begin
            r.prod[ch]     = PROD_W'(r.f) * PROD_W'(rgb_byte(ctl.add_rgb, 2'(ch)));
            r.prod[3 + ch] = PROD_W'(r.f) * PROD_W'(rgb_byte(ctl.sub_rgb, 2'(ch)));
        end
        rec_next[ST_MUL1] = r;
    end

    always_comb
    begin
        rec_t                        r;
        logic [PROD_W+MAGIC_W-1:0]   wide;
        r = rec_reg[ST_MUL2 - 1];
        for (int k = 0; k < 6; k++)
        begin
            wide = (PROD_W + MAGIC_W)'(r.prod[k]) * (PROD_W + MAGIC_W)'(DIV255_MAGIC);
            r.part[k] = wide[DIV255_SHIFT +: LEVEL_BITS];
        end
        rec_next[ST_MUL2] = r;
    end

    always_comb
    begin
        rec_t         r;
        logic [RES_W:0] up;
        logic [RES_W:0] dn;
        r = rec_reg[ST_TRIAL - 1];
        r.sum_old = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            up = {1'b0, r.item.res[ch]} + (RES_W + 1)'(r.part[ch]);
            dn = (RES_W + 1)'(r.part[3 + ch]);
            r.trial[ch] = (up > dn) ? RES_W'(up - dn) : '0;
            r.sum_old   = r.sum_old + SUM_W'(r.item.res[ch]);
        end
        rec_next[ST_TRIAL] = r;
    end

    always_comb
    begin
        rec_t             r;
        logic [SUM_W-1:0] after;
        r = rec_reg[ST_UPD - 1];
        after = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            after = after + SUM_W'(r.trial[ch]);
        end
        if (!ctl.is_xfer)
        begin
            r.item.res            = r.trial;
            r.item.drv[ctl.d_idx] = r.f;
        end
        else if (after < r.sum_old)
        begin
            r.item.res            = r.trial;
            r.item.drv[ctl.d_idx] = r.item.drv[ctl.d_idx] - r.f;
            r.item.drv[ctl.r_idx] = r.item.drv[ctl.r_idx] + r.f;
        end
        rec_next[ST_UPD] = r;
    end

    // A stage moves when it is empty or the stage after it moves, so bubbles collapse.
    always_comb
    begin
        en[N_ST-1] = !vld_reg[N_ST-1] || out_ready;
        for (int k = N_ST - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k + 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < N_ST; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k - 1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < N_ST; k++)
        begin
            if (en[k])
            begin
                rec_reg[k] <= rec_next[k];
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[N_ST-1];
    assign out_item  = rec_reg[N_ST-1].item;

endmodule
`default_nettype wire

@@ src/three_emitter_colour_fit_top.sv @@
// Throughput: one word per cycle while m_tready is high; nine fit phases of
// twelve register stages each, every phase with three pipelined restoring
// dividers and two multiplier stages. Reset (rst_n low, asynchronous) empties
// the pipeline and loads the emitter colours with pure red, green and blue.
`default_nettype none
module three_emitter_colour_fit_top (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_index,
    input  wire  [23:0] cfg_wdata,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [71:0] s_tdata,   // red_level, green_level, blue_level
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [71:0] m_tdata    // share_first, share_second, share_third
);
    import tecf_pkg::*;

    rgb_t color_a_reg;
    rgb_t color_b_reg;
    rgb_t color_c_reg;

    rgb_t [2:0]  col;
    tecf_ctl_t   ctl   [N_PHASE];
    tecf_item_t  item  [N_PHASE + 1];
    logic [N_PHASE:0] vld;
    logic [N_PHASE:0] rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_a_reg <= 24'hFF0000;
            color_b_reg <= 24'h00FF00;
            color_c_reg <= 24'h0000FF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COLOR_A: color_a_reg <= cfg_wdata;
                REG_COLOR_B: color_b_reg <= cfg_wdata;
                REG_COLOR_C: color_c_reg <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    assign col[0] = color_a_reg;
    assign col[1] = color_b_reg;
    assign col[2] = color_c_reg;

    // The first three phases are greedy fits, the rest pairwise transfers.
    always_comb
    begin
        for (int p = 0; p < N_PHASE; p++)
        begin
            ctl[p].d_idx   = PH_DONOR[p];
            ctl[p].r_idx   = PH_RECV[p];
            ctl[p].is_xfer = (p >= N_GREEDY);
            if (p < N_GREEDY)
            begin
                ctl[p].fit_rgb = col[PH_DONOR[p]];
                ctl[p].add_rgb = '0;
                ctl[p].sub_rgb = col[PH_DONOR[p]];
            end
            else
            begin
                ctl[p].fit_rgb = rgb_diff(col[PH_RECV[p]], col[PH_DONOR[p]]);
                ctl[p].add_rgb = col[PH_DONOR[p]];
                ctl[p].sub_rgb = col[PH_RECV[p]];
            end
        end
    end

    always_comb
    begin
        logic [IN_W-1:0] lv;
        item[0].drv = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            lv = s_tdata[IN_W * ch +: IN_W];
            item[0].res[ch] = (lv > IN_W'(MAXV)) ? RES_W'(MAXV) : RES_W'(lv);
        end
    end

    assign vld[0]   = s_tvalid;
    assign s_tready = rdy[0];

    for (genvar p = 0; p < N_PHASE; p++)
    begin : g_phase
        tecf_phase u_phase (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl[p]),
            .in_valid  (vld[p]),
            .in_ready  (rdy[p]),
            .in_item   (item[p]),
            .out_valid (vld[p + 1]),
            .out_ready (rdy[p + 1]),
            .out_item  (item[p + 1])
        );
    end

    assign rdy[N_PHASE] = m_tready;
    assign m_tvalid     = vld[N_PHASE];

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            m_tdata[24 * ch +: 24] = 24'(item[N_PHASE].drv[ch]);
        end
    end

endmodule
`default_nettype wire

@@ tb/sv/tb_three_emitter_colour_fit_top.sv @@
`timescale 1ns / 100ps
`default_nettype none

class share_scoreboard;
    logic [23:0] color_reg [3];
    logic [71:0] share_queue [$];
    int errors;

    function new();
        color_reg[0] = 24'hFF0000;
        color_reg[1] = 24'h00FF00;
        color_reg[2] = 24'h0000FF;
        errors = 0;
    endfunction

    function void set_color(int idx, logic [23:0] val);
        if (idx < 3)
            color_reg[idx] = val;
    endfunction

    static function logic [7:0] chan(logic [23:0] rgb, int ch);
        return rgb[16 - 8 * ch +: 8];
    endfunction

    static function longint unsigned fit(logic [23:0] rgb, longint unsigned res [3]);
        longint unsigned best;
        longint unsigned v;
        best = 64'hFFFFFF;
        for (int ch = 0; ch < 3; ch++)
        begin
            v = chan(rgb, ch);
            if (v != 0 && (255 * res[ch]) / v < best)
                best = (255 * res[ch]) / v;
        end
        return best;
    endfunction

    static function void add_part(logic [23:0] rgb, longint unsigned f,
                                  ref longint unsigned res [3]);
        for (int ch = 0; ch < 3; ch++)
            res[ch] += (f * chan(rgb, ch)) / 255;
    endfunction

    static function void sub_part(logic [23:0] rgb, longint unsigned f,
                                  ref longint unsigned res [3]);
        longint unsigned t;
        for (int ch = 0; ch < 3; ch++)
        begin
            t = (f * chan(rgb, ch)) / 255;
            res[ch] = (res[ch] > t) ? res[ch] - t : 0;
        end
    endfunction

    function void shift_drive(int d, int r, ref longint unsigned res [3],
                              ref longint unsigned drv [3]);
        logic [23:0] diff;
        longint unsigned trial [3];
        longint unsigned cap;
        longint unsigned t;
        diff = '0;
        for (int ch = 0; ch < 3; ch++)
            if (chan(color_reg[r], ch) > chan(color_reg[d], ch))
                diff[16 - 8 * ch +: 8] = chan(color_reg[r], ch) - chan(color_reg[d], ch);
        t = fit(diff, res);
        cap = 64'hFFFFFF - drv[r];
        if (drv[d] < cap)
            cap = drv[d];
        if (t > cap)
            t = cap;
        trial = res;
        add_part(color_reg[d], t, trial);
        sub_part(color_reg[r], t, trial);
        if (trial[0] + trial[1] + trial[2] < res[0] + res[1] + res[2])
        begin
            res = trial;
            drv[d] -= t;
            drv[r] += t;
        end
    endfunction

    function void note_target(logic [71:0] word);
        longint unsigned res [3];
        longint unsigned drv [3];
        for (int i = 0; i < 3; i++)
            res[i] = word[24 * i +: 24];
        for (int e = 0; e < 3; e++)
        begin
            drv[e] = fit(color_reg[e], res);
            sub_part(color_reg[e], drv[e], res);
        end
        shift_drive(0, 1, res, drv);
        shift_drive(0, 2, res, drv);
        shift_drive(1, 2, res, drv);
        shift_drive(1, 0, res, drv);
        shift_drive(2, 0, res, drv);
        shift_drive(2, 1, res, drv);
        share_queue.push_back({drv[2][23:0], drv[1][23:0], drv[0][23:0]});
    endfunction

    function void check_shares(logic [71:0] word);
        logic [71:0] want;
        string names [3];
        names = '{"share_first", "share_second", "share_third"};
        if (share_queue.size() == 0)
        begin
            $error("unexpected result word %h", word);
            errors++;
            return;
        end
        want = share_queue.pop_front();
        for (int i = 0; i < 3; i++)
            if (want[24 * i +: 24] !== word[24 * i +: 24])
            begin
                $error("%s expected %h actual %h", names[i], want[24 * i +: 24],
                       word[24 * i +: 24]);
                errors++;
            end
    endfunction
endclass

module tb_three_emitter_colour_fit_top;
    import tecf_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // red_level, green_level, blue_level
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;   // share_first, share_second, share_third

    share_scoreboard board;
    int  sink_hold;
    bit  calm;

    three_emitter_colour_fit_top DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    task automatic write_color(logic [1:0] idx, logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        board.set_color(idx, val);
        @(posedge clk);
    endtask

    task automatic send_target(logic [71:0] word);
        while (!calm && $urandom_range(99) < 19)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_target(word);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.share_queue.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    function automatic logic [23:0] rand_level();
        case ($urandom_range(5))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            2: return 24'($urandom_range(255));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] rand_color();
        logic [23:0] c;
        c = 24'($urandom);
        for (int ch = 0; ch < 3; ch++)
            case ($urandom_range(3))
                0: c[8 * ch +: 8] = 8'h00;
                1: c[8 * ch +: 8] = 8'hFF;
                default: ;
            endcase
        return c;
    endfunction

    // Receiver: random stalls, plus one long hold-off that the main test sequence arms.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_shares(m_tdata);
        if (sink_hold > 0)
        begin
            sink_hold <= sink_hold - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= calm || ($urandom_range(99) >= 19);
    end

    initial
    begin
        logic [71:0] word;
        board     = new();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_COLOR_A;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        sink_hold = 0;
        calm      = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset colors, extremes, then all-zero color and mixed colors.
        send_target({24'h000000, 24'h000000, 24'h000000});
        send_target({24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF});
        send_target({24'h000000, 24'h000000, 24'hFFFFFF});
        send_target({24'h123456, 24'hABCDEF, 24'h000001});
        send_target({24'hFFFFFF, 24'h000000, 24'h800000});
        drain();
        write_color(REG_COLOR_A, 24'h000000);
        write_color(REG_COLOR_B, 24'hFFFFFF);
        write_color(REG_COLOR_C, 24'h010101);
        // Out-of-range index must be ignored.
        cfg_we <= 1'b1; cfg_index <= 2'd3; cfg_wdata <= 24'h5A5A5A;
        @(posedge clk);
        cfg_we <= 1'b0;
        send_target({24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF});
        send_target({24'h000001, 24'h7FFFFF, 24'hFFFFFE});
        send_target({24'h000000, 24'h000000, 24'h000000});
        drain();
        write_color(REG_COLOR_A, 24'hFF8000);
        write_color(REG_COLOR_B, 24'h00FFFF);
        write_color(REG_COLOR_C, 24'hFF00FF);
        send_target({24'hFFFFFF, 24'h000000, 24'hFFFFFF});
        send_target({24'h00FFFF, 24'hFFFFFF, 24'h000100});

        // Random phases with fresh colors, all white in phase 7; phase 2 holds the sink
        // off long enough to back the pipeline up, phase 4 runs without idling.
        for (int ph = 0; ph < 8; ph++)
        begin
            drain();
            if (ph == 7)
            begin
                write_color(REG_COLOR_A, 24'hFFFFFF);
                write_color(REG_COLOR_B, 24'hFFFFFF);
                write_color(REG_COLOR_C, 24'hFFFFFF);
            end
            else
            begin
                write_color(REG_COLOR_A, rand_color());
                write_color(REG_COLOR_B, rand_color());
                write_color(REG_COLOR_C, rand_color());
            end
            calm = (ph == 4);
            if (ph == 2)
                sink_hold = 400;
            for (int i = 0; i < 180; i++)
            begin
                word = {rand_level(), rand_level(), rand_level()};
                send_target(word);
            end
        end
        calm = 0;
        drain();

        if (board.errors == 0 && board.share_queue.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
src/tecf_pkg.sv
src/tecf_phase.sv
src/three_emitter_colour_fit_top.sv
tb/sv/tb_three_emitter_colour_fit_top.sv
